/* hw/rtl/hashed_symbol_table_defines.svh */
// assertion macros
`ifndef HASHED_SYMBOL_TABLE_DEFINES_SVH
`define HASHED_SYMBOL_TABLE_DEFINES_SVH
`ifndef SYNTH
`define HST_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("hst check");
`define HST_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("hst check");
`else
`define HST_ASSERT_IMP(label, clk, rst, a, c)
`define HST_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

/* hw/rtl/hst_pkg.sv */
package hst_pkg;
  localparam int FuncSlots = 16;
  localparam int SubSlots = 16;
  localparam int LabelSlots = 16;
  localparam logic [6:0] GotoLimit = 7'd64;

  typedef enum logic [3:0] {
    CMD_CLEAR = 4'd0, CMD_ADD_GLOBAL = 4'd1, CMD_ADD_FUNC = 4'd2, CMD_ADD_SUB = 4'd3,
    CMD_CLASSIFY = 4'd4, CMD_CLASSIFY_EXPR = 4'd5, CMD_IS_GLOBAL = 4'd6,
    CMD_FUNC_ADDR = 4'd7, CMD_SUB_ADDR = 4'd8, CMD_GOTO = 4'd9
  } cmd_t;

  localparam logic [1:0] CLS_LOCAL = 2'd0;
  localparam logic [1:0] CLS_GLOBAL = 2'd1;
  localparam logic [1:0] CLS_FUNC = 2'd2;
  localparam logic [1:0] CLS_SUB = 2'd3;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

  typedef struct packed {
    logic [3:0] command;
    logic [31:0] name_hash;
    logic [7:0] name_len;
    logic [31:0] body_ip;
  } in_item_t;

  typedef struct packed {
    logic ok;
    logic [1:0] ident_class;
    logic [31:0] found_ip;
  } out_item_t;
endpackage

/* hw/rtl/hst_front.sv */
module hst_front (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  hst_pkg::in_item_t in_item,
  output logic q_valid,
  input  logic q_take,
  output hst_pkg::in_item_t q_item
);
  hst_pkg::in_item_t buf0, buf1;
  logic [1:0] cnt;
  logic do_push;

  assign full = cnt == 2'd2;
  assign do_push = push && !full;
  assign q_valid = cnt != 2'd0;
  assign q_item = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, do_push} - {1'b0, q_take && q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (q_take && q_valid) begin
      buf0 <= (cnt == 2'd2) ? buf1 : in_item;
      if (do_push) buf1 <= in_item;
    end else if (do_push) begin
      if (cnt == 2'd0) buf0 <= in_item;
      else buf1 <= in_item;
    end
  end
endmodule

/* hw/rtl/hst_back.sv */
`include "hashed_symbol_table_defines.svh"
module hst_back #(
  parameter int FUNC_SLOTS = hst_pkg::FuncSlots,
  parameter int SUB_SLOTS = hst_pkg::SubSlots,
  parameter int LABEL_SLOTS = hst_pkg::LabelSlots
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_take,
  input  hst_pkg::in_item_t q_item,
  output logic empty,
  input  logic pop,
  output hst_pkg::out_item_t out_item
);
  localparam int FW = $clog2(FUNC_SLOTS + 1);
  localparam int SW = $clog2(SUB_SLOTS + 1);
  localparam int LW = $clog2(LABEL_SLOTS + 1);
  localparam int FI = (FUNC_SLOTS > 1) ? $clog2(FUNC_SLOTS) : 1;
  localparam int SI = (SUB_SLOTS > 1) ? $clog2(SUB_SLOTS) : 1;
  localparam int LI = (LABEL_SLOTS > 1) ? $clog2(LABEL_SLOTS) : 1;
  localparam int MAXS = (FUNC_SLOTS > SUB_SLOTS) ? FUNC_SLOTS : SUB_SLOTS;
  localparam int M = (MAXS > LABEL_SLOTS) ? MAXS : LABEL_SLOTS;
  localparam int IW = $clog2(M + 1);

  logic [255:0] gmap, fmap, smap;
  logic [31:0] fhash [FUNC_SLOTS];
  logic [31:0] faddr [FUNC_SLOTS];
  logic [31:0] shash [SUB_SLOTS];
  logic [31:0] saddr [SUB_SLOTS];
  logic [15:0] lhash [LABEL_SLOTS];
  logic [6:0] lcnt [LABEL_SLOTS];
  logic [FW-1:0] fused;
  logic [SW-1:0] sused;
  logic [LW-1:0] lused;

  hst_pkg::state_t state, state_next;
  hst_pkg::in_item_t cur;
  logic [IW-1:0] idx;
  logic out_full;
  logic [7:0] bitn;
  logic [15:0] lkey;
  logic scan_end, scan_hit;
  logic [31:0] hit_addr;
  hst_pkg::cmd_t cmd;
  hst_pkg::out_item_t first_res;
  logic func_room, sub_room;

  assign cmd = hst_pkg::cmd_t'(cur.command);
  assign bitn = q_item.name_hash[7:0];
  assign lkey = cur.name_hash[15:0];
  assign empty = !out_full;
  assign func_room = fused < FW'(FUNC_SLOTS);
  assign sub_room = sused < SW'(SUB_SLOTS);

  always_comb begin
    first_res = '0;
    case (hst_pkg::cmd_t'(q_item.command))
      hst_pkg::CMD_CLEAR, hst_pkg::CMD_ADD_GLOBAL: first_res.ok = 1'b1;
      hst_pkg::CMD_ADD_FUNC: first_res.ok = func_room;
      hst_pkg::CMD_ADD_SUB: first_res.ok = sub_room;
      hst_pkg::CMD_CLASSIFY: begin
        first_res.ok = gmap[bitn] | fmap[bitn] | smap[bitn];
        first_res.ident_class = gmap[bitn] ? hst_pkg::CLS_GLOBAL :
          fmap[bitn] ? hst_pkg::CLS_FUNC :
          smap[bitn] ? hst_pkg::CLS_SUB : hst_pkg::CLS_LOCAL;
      end
      hst_pkg::CMD_CLASSIFY_EXPR: begin
        first_res.ok = gmap[bitn] | fmap[bitn];
        first_res.ident_class = gmap[bitn] ? hst_pkg::CLS_GLOBAL :
          fmap[bitn] ? hst_pkg::CLS_FUNC : hst_pkg::CLS_LOCAL;
      end
      hst_pkg::CMD_IS_GLOBAL: first_res.ok = gmap[bitn];
      default: begin
      end
    endcase
  end

  always_comb begin
    scan_end = 1'b1;
    scan_hit = 1'b0;
    hit_addr = '0;
    case (cmd)
      hst_pkg::CMD_FUNC_ADDR: begin
        scan_end = idx >= IW'(fused);
        if (!scan_end) begin
          scan_hit = fhash[idx[FI-1:0]] == cur.name_hash;
          hit_addr = faddr[idx[FI-1:0]];
        end
      end
      hst_pkg::CMD_SUB_ADDR: begin
        scan_end = idx >= IW'(sused);
        if (!scan_end) begin
          scan_hit = shash[idx[SI-1:0]] == cur.name_hash;
          hit_addr = saddr[idx[SI-1:0]];
        end
      end
      hst_pkg::CMD_GOTO: begin
        scan_end = idx >= IW'(lused);
        if (!scan_end)
          scan_hit = lhash[idx[LI-1:0]] == lkey;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      hst_pkg::ST_IDLE: if (q_valid && !out_full) state_next = hst_pkg::ST_SCAN;
      hst_pkg::ST_SCAN: if (scan_end || scan_hit) state_next = hst_pkg::ST_DONE;
      hst_pkg::ST_DONE: if (!out_full) state_next = hst_pkg::ST_IDLE;
      default: state_next = hst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_take = 1'b0;
    case (state)
      hst_pkg::ST_IDLE: q_take = q_valid && !out_full;
      default: q_take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hst_pkg::ST_IDLE;
      out_full <= 1'b0;
      gmap <= '0;
      fmap <= '0;
      smap <= '0;
      fused <= '0;
      sused <= '0;
      lused <= '0;
      idx <= '0;
    end else begin
      state <= state_next;
      if (pop && out_full) out_full <= 1'b0;
      case (state)
        hst_pkg::ST_IDLE: if (q_take) begin
          cur <= q_item;
          idx <= '0;
          out_item <= first_res;
          case (hst_pkg::cmd_t'(q_item.command))
            hst_pkg::CMD_CLEAR: begin
              gmap <= '0;
              fmap <= '0;
              smap <= '0;
              fused <= '0;
              sused <= '0;
              lused <= '0;
            end
            hst_pkg::CMD_ADD_GLOBAL: gmap[bitn] <= 1'b1;
            hst_pkg::CMD_ADD_FUNC: begin
              fmap[bitn] <= 1'b1;
              if (func_room) begin
                fhash[fused[FI-1:0]] <= q_item.name_hash;
                faddr[fused[FI-1:0]] <= q_item.body_ip;
                fused <= fused + 1'b1;
              end
            end
            hst_pkg::CMD_ADD_SUB: begin
              smap[bitn] <= 1'b1;
              if (sub_room) begin
                shash[sused[SI-1:0]] <= q_item.name_hash;
                saddr[sused[SI-1:0]] <= q_item.body_ip;
                sused <= sused + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        hst_pkg::ST_SCAN: begin
          idx <= idx + 1'b1;
          case (cmd)
            hst_pkg::CMD_FUNC_ADDR, hst_pkg::CMD_SUB_ADDR: if (scan_hit) begin
              out_item.ok <= 1'b1;
              out_item.found_ip <= hit_addr + {24'd0, cur.name_len} + 32'd1;
            end
            hst_pkg::CMD_GOTO: begin
              if (scan_hit) begin
                if (lcnt[idx[LI-1:0]] < hst_pkg::GotoLimit) begin
                  lcnt[idx[LI-1:0]] <= lcnt[idx[LI-1:0]] + 7'd1;
                  out_item.ok <= 1'b1;
                end
              end else if (scan_end) begin
                out_item.ok <= 1'b1;
                if (lused < LW'(LABEL_SLOTS)) begin
                  lhash[lused[LI-1:0]] <= lkey;
                  lcnt[lused[LI-1:0]] <= 7'd1;
                  lused <= lused + 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
        hst_pkg::ST_DONE: if (!out_full) out_full <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  `HST_ASSERT_IMP(a_take_idle, clk, rst, q_take, state == hst_pkg::ST_IDLE)
  `HST_ASSERT_NEXT(a_done_fill, clk, rst, state == hst_pkg::ST_DONE && !out_full, out_full)
  `HST_ASSERT_IMP(a_fused_max, clk, rst, 1'b1, fused <= FW'(FUNC_SLOTS))
  `HST_ASSERT_IMP(a_lused_max, clk, rst, 1'b1, lused <= LW'(LABEL_SLOTS))
endmodule

/* hw/rtl/hashed_symbol_table.sv */
// channel | direction | handshake
// in      | input     | push / full
// out     | output    | pop / empty
// a clear, add, classify or is-global item passes through the idle, scan and done states in the back end
// an address lookup or goto check scans its table slot by slot in the scan state (serial scan)
// rst is synchronous and empties all maps, tables and counts
// a two-beat queue lets the front accept while the back waits on pop
module hashed_symbol_table #(
  parameter int FUNC_SLOTS = hst_pkg::FuncSlots,
  parameter int SUB_SLOTS = hst_pkg::SubSlots,
  parameter int LABEL_SLOTS = hst_pkg::LabelSlots
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  hst_pkg::in_item_t in_item,
  output logic empty,
  input  logic pop,
  output hst_pkg::out_item_t out_item
);
  logic q_valid, q_take;
  hst_pkg::in_item_t q_item;

  hst_front u_front (
    .clk, .rst, .push, .full, .in_item, .q_valid, .q_take, .q_item
  );

  hst_back #(
    .FUNC_SLOTS(FUNC_SLOTS), .SUB_SLOTS(SUB_SLOTS), .LABEL_SLOTS(LABEL_SLOTS)
  ) u_back (
    .clk, .rst, .q_valid, .q_take, .q_item, .empty, .pop, .out_item
  );
endmodule

/* bench/hashed_symbol_table_test.sv */
`timescale 1ns / 100ps

module hashed_symbol_table_test;

  localparam int WatchLimit = 4000;

  logic clk;
  logic rst;
  logic push;
  logic full;
  hst_pkg::in_item_t in_item;
  logic empty;
  logic pop;
  hst_pkg::out_item_t out_item;

  hashed_symbol_table dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  // predictor state
  logic global_bits [256];
  logic func_bits [256];
  logic sub_bits [256];
  logic [31:0] func_keys [hst_pkg::FuncSlots];
  logic [31:0] func_bodies [hst_pkg::FuncSlots];
  int func_fill;
  logic [31:0] sub_keys [hst_pkg::SubSlots];
  logic [31:0] sub_bodies [hst_pkg::SubSlots];
  int sub_fill;
  logic [15:0] label_keys [hst_pkg::LabelSlots];
  logic [6:0] label_uses [hst_pkg::LabelSlots];
  int label_fill;

  hst_pkg::out_item_t pending_results[$];
  int errors;
  int watch;
  bit steady;
  bit timed_out;

  typedef struct {
    hst_pkg::in_item_t beat;
    bit typed;
    hst_pkg::out_item_t want;
  } row_t;

  row_t rows[$];

  function automatic void wipe_tables();
    for (int i = 0; i < 256; i++) begin
      global_bits[i] = 0;
      func_bits[i] = 0;
      sub_bits[i] = 0;
    end
    for (int i = 0; i < hst_pkg::LabelSlots; i++) begin
      label_keys[i] = '0;
      label_uses[i] = '0;
    end
    func_fill = 0;
    sub_fill = 0;
    label_fill = 0;
  endfunction

  function automatic hst_pkg::out_item_t lookup_symbol(hst_pkg::in_item_t b);
    hst_pkg::out_item_t r;
    logic [7:0] bi;
    logic g;
    logic f;
    logic s;
    bit hit;
    r = '0;
    bi = b.name_hash[7:0];
    g = global_bits[bi];
    f = func_bits[bi];
    s = sub_bits[bi];
    case (b.command)
      hst_pkg::CMD_CLEAR: begin
        wipe_tables();
        r.ok = 1;
      end
      hst_pkg::CMD_ADD_GLOBAL: begin
        global_bits[bi] = 1;
        r.ok = 1;
      end
      hst_pkg::CMD_ADD_FUNC: begin
        func_bits[bi] = 1;
        if (func_fill < hst_pkg::FuncSlots) begin
          func_keys[func_fill] = b.name_hash;
          func_bodies[func_fill] = b.body_ip;
          func_fill++;
          r.ok = 1;
        end
      end
      hst_pkg::CMD_ADD_SUB: begin
        sub_bits[bi] = 1;
        if (sub_fill < hst_pkg::SubSlots) begin
          sub_keys[sub_fill] = b.name_hash;
          sub_bodies[sub_fill] = b.body_ip;
          sub_fill++;
          r.ok = 1;
        end
      end
      hst_pkg::CMD_CLASSIFY: begin
        r.ident_class = g ? hst_pkg::CLS_GLOBAL : f ? hst_pkg::CLS_FUNC :
                        s ? hst_pkg::CLS_SUB : hst_pkg::CLS_LOCAL;
        r.ok = r.ident_class != hst_pkg::CLS_LOCAL;
      end
      hst_pkg::CMD_CLASSIFY_EXPR: begin
        r.ident_class = g ? hst_pkg::CLS_GLOBAL : f ? hst_pkg::CLS_FUNC :
                        hst_pkg::CLS_LOCAL;
        r.ok = r.ident_class != hst_pkg::CLS_LOCAL;
      end
      hst_pkg::CMD_IS_GLOBAL: r.ok = g;
      hst_pkg::CMD_FUNC_ADDR: begin
        hit = 0;
        for (int i = 0; i < func_fill && !hit; i++)
          if (func_keys[i] == b.name_hash) begin
            hit = 1;
            r.found_ip = func_bodies[i] + 32'(b.name_len) + 32'd1;
          end
        r.ok = hit;
      end
      hst_pkg::CMD_SUB_ADDR: begin
        hit = 0;
        for (int i = 0; i < sub_fill && !hit; i++)
          if (sub_keys[i] == b.name_hash) begin
            hit = 1;
            r.found_ip = sub_bodies[i] + 32'(b.name_len) + 32'd1;
          end
        r.ok = hit;
      end
      hst_pkg::CMD_GOTO: begin
        hit = 0;
        r.ok = 1;
        for (int i = 0; i < label_fill && !hit; i++)
          if (label_keys[i] == b.name_hash[15:0]) begin
            hit = 1;
            if (label_uses[i] >= hst_pkg::GotoLimit) r.ok = 0;
            else label_uses[i]++;
          end
        if (!hit && label_fill < hst_pkg::LabelSlots) begin
          label_keys[label_fill] = b.name_hash[15:0];
          label_uses[label_fill] = 7'd1;
          label_fill++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic hst_pkg::in_item_t mk(logic [3:0] c, logic [31:0] h, logic [7:0] l,
                                           logic [31:0] ip);
    hst_pkg::in_item_t b;
    b.command = c;
    b.name_hash = h;
    b.name_len = l;
    b.body_ip = ip;
    return b;
  endfunction

  function automatic hst_pkg::out_item_t res(logic k, logic [1:0] c, logic [31:0] ip);
    hst_pkg::out_item_t r;
    r.ok = k;
    r.ident_class = c;
    r.found_ip = ip;
    return r;
  endfunction

  function automatic void add_row(hst_pkg::in_item_t b, bit typed, hst_pkg::out_item_t w);
    row_t r;
    r.beat = b;
    r.typed = typed;
    r.want = w;
    rows.push_back(r);
  endfunction

  function automatic logic [3:0] pick_command();
    int p;
    p = $urandom_range(0, 99);
    if (p < 2) return hst_pkg::CMD_CLEAR;
    if (p < 4) return 4'($urandom_range(10, 15));
    return 4'($urandom_range(1, 9));
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  task automatic send_beat(hst_pkg::in_item_t b);
    while (!steady && $urandom_range(0, 99) < 34) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1;
    in_item <= b;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // expectation from table or predictor
  task automatic issue(hst_pkg::in_item_t b, bit typed, hst_pkg::out_item_t w);
    hst_pkg::out_item_t p;
    p = lookup_symbol(b);
    if (typed && p !== w) begin
      $display("%0t directed row mismatch in predictor: expected %h actual %h",
               $time, w, p);
      errors++;
    end
    pending_results.push_back(typed ? w : p);
    send_beat(b);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 0;
    end else begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected beat: expected none actual %h", $time, out_item);
          errors++;
        end else begin
          hst_pkg::out_item_t w;
          w = pending_results.pop_front();
          if (out_item.ok !== w.ok) begin
            $display("%0t ok: expected %b actual %b", $time, w.ok, out_item.ok);
            errors++;
          end
          if (out_item.ident_class !== w.ident_class) begin
            $display("%0t ident_class: expected %0d actual %0d", $time,
                     w.ident_class, out_item.ident_class);
            errors++;
          end
          if (out_item.found_ip !== w.found_ip) begin
            $display("%0t found_ip: expected %h actual %h", $time, w.found_ip,
                     out_item.found_ip);
            errors++;
          end
        end
      end
      pop <= steady || $urandom_range(0, 99) >= 34;
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) watch <= 0;
    else watch <= watch + 1;
    if (watch >= WatchLimit && !timed_out) begin
      timed_out = 1;
      $display("hashed_symbol_table_test: errors");
      $finish;
    end
  end

  initial begin
    logic [31:0] pool [8];
    logic [3:0] c;
    hst_pkg::in_item_t b;
    errors = 0;
    watch = 0;
    steady = 0;
    timed_out = 0;
    rst = 1;
    push = 0;
    pop = 0;
    in_item = '0;
    wipe_tables();
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    add_row(mk(hst_pkg::CMD_CLASSIFY, 32'h0, 8'h0, 32'h0), 1,
            res(0, hst_pkg::CLS_LOCAL, 0));
    add_row(mk(hst_pkg::CMD_FUNC_ADDR, 32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF), 1,
            res(0, hst_pkg::CLS_LOCAL, 0));
    add_row(mk(hst_pkg::CMD_ADD_FUNC, 32'hFFFFFFFF, 8'h0, 32'hFFFFFFFF), 1,
            res(1, hst_pkg::CLS_LOCAL, 0));
    add_row(mk(hst_pkg::CMD_FUNC_ADDR, 32'hFFFFFFFF, 8'hFF, 32'h0), 1,
            res(1, hst_pkg::CLS_LOCAL, 32'hFF));
    add_row(mk(hst_pkg::CMD_ADD_SUB, 32'h000000FF, 8'h0, 32'h12345678), 1,
            res(1, hst_pkg::CLS_LOCAL, 0));
    add_row(mk(hst_pkg::CMD_CLASSIFY, 32'h000000FF, 8'h0, 32'h0), 0, '0);
    add_row(mk(hst_pkg::CMD_SUB_ADDR, 32'h000000FF, 8'h10, 32'h0), 0, '0);
    add_row(mk(hst_pkg::CMD_ADD_SUB, 32'h00000042, 8'h0, 32'h0), 0, '0);
    add_row(mk(hst_pkg::CMD_CLASSIFY, 32'h00000042, 8'h0, 32'h0), 1,
            res(1, hst_pkg::CLS_SUB, 0));
    add_row(mk(hst_pkg::CMD_CLASSIFY_EXPR, 32'h00000042, 8'h0, 32'h0), 1,
            res(0, hst_pkg::CLS_LOCAL, 0));
    add_row(mk(hst_pkg::CMD_ADD_GLOBAL, 32'hAAAA5542, 8'h0, 32'h0), 1,
            res(1, hst_pkg::CLS_LOCAL, 0));
    add_row(mk(hst_pkg::CMD_CLASSIFY, 32'h00000042, 8'h0, 32'h0), 1,
            res(1, hst_pkg::CLS_GLOBAL, 0));
    add_row(mk(hst_pkg::CMD_CLASSIFY_EXPR, 32'h00000042, 8'h0, 32'h0), 1,
            res(1, hst_pkg::CLS_GLOBAL, 0));
    add_row(mk(hst_pkg::CMD_IS_GLOBAL, 32'h55555542, 8'h0, 32'h0), 1,
            res(1, hst_pkg::CLS_LOCAL, 0));
    add_row(mk(hst_pkg::CMD_IS_GLOBAL, 32'h0, 8'h0, 32'h0), 1,
            res(0, hst_pkg::CLS_LOCAL, 0));
    add_row(mk(hst_pkg::CMD_GOTO, 32'hFFFF0000, 8'h0, 32'h0), 1,
            res(1, hst_pkg::CLS_LOCAL, 0));
    add_row(mk(4'd15, 32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF), 1,
            res(0, hst_pkg::CLS_LOCAL, 0));
    add_row(mk(4'd10, 32'h000000FF, 8'h0, 32'h0), 1, res(0, hst_pkg::CLS_LOCAL, 0));
    add_row(mk(hst_pkg::CMD_CLEAR, 32'h0, 8'h0, 32'h0), 1,
            res(1, hst_pkg::CLS_LOCAL, 0));
    add_row(mk(hst_pkg::CMD_CLASSIFY, 32'h000000FF, 8'h0, 32'h0), 1,
            res(0, hst_pkg::CLS_LOCAL, 0));
    add_row(mk(hst_pkg::CMD_FUNC_ADDR, 32'hFFFFFFFF, 8'h0, 32'h0), 1,
            res(0, hst_pkg::CLS_LOCAL, 0));
    foreach (rows[i]) issue(rows[i].beat, rows[i].typed, rows[i].want);

    // fill function and sub tables past capacity
    for (int i = 0; i < hst_pkg::FuncSlots + 2; i++)
      issue(mk(hst_pkg::CMD_ADD_FUNC, $urandom, 8'($urandom), $urandom), 0, '0);
    for (int i = 0; i < hst_pkg::SubSlots + 2; i++)
      issue(mk(hst_pkg::CMD_ADD_SUB, $urandom, 8'($urandom), $urandom), 0, '0);
    // goto label to its limit, then a full label table
    for (int i = 0; i < 66; i++)
      issue(mk(hst_pkg::CMD_GOTO, {16'($urandom), 16'h0000}, 8'h0, 32'h0), 0, '0);
    for (int i = 0; i < hst_pkg::LabelSlots + 3; i++)
      issue(mk(hst_pkg::CMD_GOTO, 32'($urandom_range(1, 40)), 8'h0, 32'h0), 0, '0);

    // wait for drain before randomized traffic
    push <= 0;
    while (pending_results.size() != 0) @(posedge clk);

    for (int i = 0; i < 460; i++) begin
      if (i % 8 == 0)
        for (int k = 0; k < 8; k++) pool[k] = $urandom;
      steady = (i >= 250 && i < 350);
      c = pick_command();
      b = mk(c, $urandom_range(0, 3) != 0 ? pool[$urandom_range(0, 7)] : $urandom,
             8'($urandom), $urandom);
      if (c == hst_pkg::CMD_GOTO && $urandom_range(0, 1))
        b.name_hash[15:0] = 16'($urandom_range(0, 5));
      issue(b, 0, '0);
    end
    steady = 0;
    push <= 0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("hashed_symbol_table_test: clean");
    end else begin
      $display("hashed_symbol_table_test: errors");
    end
    $finish;
  end

endmodule
